FILE: hdl/skt_pkg.sv
package skt_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CALL   = 2'd2,
    OP_EXISTS = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    func_t       func;
    logic [31:0] key;
    logic [31:0] handler;
  } in_t;

  typedef struct packed {
    status_t     status;
    logic        found;
    logic [31:0] handler_out;
    logic [63:0] use_count;
    logic [6:0]  entry_count;
  } out_t;

  // One table row as it sits in the RAM.
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] handler;
    logic [63:0] count;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SCMP,
    S_CHECK,
    S_INS_SHIFT,
    S_INS_WRITE,
    S_REM_SHIFT
  } state_t;

endpackage

FILE: hdl/skt_ram.sv
module skt_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/sorted_key_table_with_hit_counts_core.sv
// Channel   Handshake                Payload            Direction
// -------   ----------------------   ----------------   ---------
// command   start / busy             cmd   (skt_pkg::in_t)    in
// result    done (one-cycle strobe)  rsp   (skt_pkg::out_t)   out
//
// A command transaction is taken at a rising edge with start high and busy low.
// Lookup is a binary search with a registered RAM read: each halving step reads the
// midpoint (S_SEARCH) and then compares it (S_SCMP); call and exists end after S_CHECK.
// Insert shifts the higher rows up, then writes the new row; remove shifts the higher rows down.
// Reset (rst, synchronous) clears only the occupancy, the control state and the done strobe.
// Done follows for exactly one cycle, cannot be stalled, and a new command may be taken then.
module sorted_key_table_with_hit_counts_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  skt_pkg::in_t  cmd,
  output logic          busy,
  output logic          done,
  output skt_pkg::out_t rsp
);

  // Row address width and the width of a position/count that may equal the depth.
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = $bits(skt_pkg::entry_t);

  skt_pkg::state_t state, state_next;

  // Latched command transaction.
  skt_pkg::func_t op_q;
  logic [31:0]    key_q;
  logic [31:0]    handler_q;

  // Search bounds; when the search ends, lo is the insert or hit position.
  logic [CW-1:0] lo, lo_next;
  logic [CW-1:0] hi, hi_next;
  // Row being written during a shift.
  logic [CW-1:0] idx, idx_next;
  // Number of valid rows.
  logic [CW-1:0] occ, occ_next;

  logic          done_next;
  skt_pkg::out_t rsp_next;

  logic [CW-1:0] mid;
  logic [CW-1:0] rd_pos;
  logic [CW:0]   idx_p2;
  logic          hit;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [EW-1:0]    ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [EW-1:0]    ram_rdata;
  skt_pkg::entry_t  rd_entry;
  skt_pkg::entry_t  wr_entry;

  skt_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_entry  = skt_pkg::entry_t'(ram_rdata);
  assign ram_wdata = EW'(wr_entry);

  // Midpoint never reaches hi, so it always addresses a valid row.
  assign mid    = lo + ((hi - lo) >> 1);
  assign idx_p2 = {1'b0, idx} + (CW + 1)'(2);
  // The row at the final position was read in the last search cycle.
  assign hit    = (lo < occ) && (rd_entry.key == key_q);

  assign busy = (state != skt_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skt_pkg::S_IDLE;
      occ   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    lo  <= lo_next;
    hi  <= hi_next;
    idx <= idx_next;
    rsp <= rsp_next;
    if (start && !busy) begin
      op_q      <= cmd.func;
      key_q     <= cmd.key;
      handler_q <= cmd.handler;
    end
  end

  always_comb begin
    state_next = state;
    lo_next    = lo;
    hi_next    = hi;
    idx_next   = idx;
    occ_next   = occ;
    done_next  = 1'b0;
    rsp_next   = rsp;
    ram_we     = 1'b0;
    ram_waddr  = idx[AW-1:0];
    wr_entry   = rd_entry;
    rd_pos     = '0;

    unique case (state)
      skt_pkg::S_IDLE: begin
        if (start) begin
          lo_next    = '0;
          hi_next    = occ;
          state_next = skt_pkg::S_SEARCH;
        end
      end

      skt_pkg::S_SEARCH: begin
        // Read the midpoint while the range is open, else the final position.
        if (lo < hi) begin
          rd_pos     = mid;
          state_next = skt_pkg::S_SCMP;
        end else begin
          rd_pos     = lo;
          state_next = skt_pkg::S_CHECK;
        end
      end

      skt_pkg::S_SCMP: begin
        if (rd_entry.key < key_q) begin
          lo_next = mid + 1'b1;
        end else begin
          hi_next = mid;
        end
        state_next = skt_pkg::S_SEARCH;
      end

      skt_pkg::S_CHECK: begin
        rsp_next.found       = hit;
        rsp_next.handler_out = '0;
        rsp_next.use_count   = '0;
        rsp_next.status      = skt_pkg::ST_OK;
        rsp_next.entry_count = 7'(occ);
        state_next           = skt_pkg::S_IDLE;
        done_next            = 1'b1;

        unique case (op_q)
          skt_pkg::OP_INSERT: begin
            if (hit) begin
              rsp_next.status = skt_pkg::ST_DUP;
            end else if (occ >= CW'(TABLE_DEPTH)) begin
              rsp_next.status = skt_pkg::ST_FULL;
            end else begin
              done_next = 1'b0;
              if (occ > lo) begin
                // Move the top row up first, then work downward.
                rd_pos     = occ - 1'b1;
                idx_next   = occ;
                state_next = skt_pkg::S_INS_SHIFT;
              end else begin
                state_next = skt_pkg::S_INS_WRITE;
              end
            end
          end

          skt_pkg::OP_REMOVE: begin
            if (!hit) begin
              rsp_next.status = skt_pkg::ST_MISSING;
            end else if (CW'(lo + 1'b1) < occ) begin
              done_next  = 1'b0;
              rd_pos     = lo + 1'b1;
              idx_next   = lo;
              state_next = skt_pkg::S_REM_SHIFT;
            end else begin
              occ_next             = occ - 1'b1;
              rsp_next.entry_count = 7'(occ_next);
            end
          end

          skt_pkg::OP_CALL: begin
            if (!hit) begin
              rsp_next.status = skt_pkg::ST_MISSING;
            end else begin
              // Count wraps at 64 bits like any unsigned add.
              wr_entry.count       = rd_entry.count + 64'd1;
              ram_we               = 1'b1;
              ram_waddr            = lo[AW-1:0];
              rsp_next.handler_out = rd_entry.handler;
              rsp_next.use_count   = wr_entry.count;
            end
          end

          skt_pkg::OP_EXISTS: begin
            if (!hit) begin
              rsp_next.status = skt_pkg::ST_MISSING;
            end
          end

          default: begin
            rsp_next.status = skt_pkg::ST_MISSING;
          end
        endcase
      end

      skt_pkg::S_INS_SHIFT: begin
        // The row read last cycle is idx-1; store it at idx and fetch the next one down.
        ram_we = 1'b1;
        if ((idx - 1'b1) > lo) begin
          rd_pos   = idx - CW'(2);
          idx_next = idx - 1'b1;
        end else begin
          state_next = skt_pkg::S_INS_WRITE;
        end
      end

      skt_pkg::S_INS_WRITE: begin
        wr_entry.key         = key_q;
        wr_entry.handler     = handler_q;
        wr_entry.count       = '0;
        ram_we               = 1'b1;
        ram_waddr            = lo[AW-1:0];
        occ_next             = occ + 1'b1;
        rsp_next.status      = skt_pkg::ST_OK;
        rsp_next.found       = 1'b0;
        rsp_next.handler_out = '0;
        rsp_next.use_count   = '0;
        rsp_next.entry_count = 7'(occ_next);
        done_next            = 1'b1;
        state_next           = skt_pkg::S_IDLE;
      end

      skt_pkg::S_REM_SHIFT: begin
        // The row read last cycle is idx+1; store it at idx and fetch the next one up.
        ram_we = 1'b1;
        if (idx_p2 < {1'b0, occ}) begin
          rd_pos   = idx_p2[CW-1:0];
          idx_next = idx + 1'b1;
        end else begin
          occ_next             = occ - 1'b1;
          rsp_next.status      = skt_pkg::ST_OK;
          rsp_next.found       = 1'b1;
          rsp_next.handler_out = '0;
          rsp_next.use_count   = '0;
          rsp_next.entry_count = 7'(occ_next);
          done_next            = 1'b1;
          state_next           = skt_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = skt_pkg::S_IDLE;
      end
    endcase

    ram_raddr = rd_pos[AW-1:0];
  end

  // A result only follows a cycle in which a command was being worked on.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a command in progress");

  // The occupancy never exceeds the table depth.
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(TABLE_DEPTH))
    else $error("occupancy beyond table depth");

  // The table is only written while a command is in progress.
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> busy)
    else $error("table write while idle");

  // A successful insert grows the table by exactly one row.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    done && (op_q == skt_pkg::OP_INSERT) && (rsp.status == skt_pkg::ST_OK)
      |-> occ == $past(occ) + 1'b1)
    else $error("successful insert did not add one row");

endmodule

FILE: tb/skt_result_checker.sv
module skt_result_checker #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  skt_pkg::in_t  cmd,
  input  logic          done,
  input  skt_pkg::out_t rsp,
  output int            fail_count,
  output int            pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the table, kept sorted by key like the block's RAM.
  logic [31:0] row_key     [TABLE_DEPTH];
  logic [31:0] row_handler [TABLE_DEPTH];
  logic [63:0] row_uses    [TABLE_DEPTH];
  int          rows_held;

  skt_pkg::out_t expected_rsp_q[$];
  int            mismatches = 0;

  // Applies one command to the shadow table and returns the response it earns.
  function automatic skt_pkg::out_t table_outcome(skt_pkg::in_t c);
    int            lo, hi, mid, pos, i;
    logic          hit;
    skt_pkg::out_t r;
    lo = 0;
    hi = rows_held;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (row_key[mid] < c.key) lo = mid + 1;
      else hi = mid;
    end
    pos = lo;
    hit = (pos < rows_held) && (row_key[pos] == c.key);
    r = '0;
    r.status = skt_pkg::ST_OK;
    r.found = hit;
    case (c.func)
      skt_pkg::OP_INSERT: begin
        if (hit) begin
          r.status = skt_pkg::ST_DUP;
        end else if (rows_held >= TABLE_DEPTH) begin
          r.status = skt_pkg::ST_FULL;
        end else begin
          for (i = rows_held; i > pos; i--) begin
            row_key[i] = row_key[i-1];
            row_handler[i] = row_handler[i-1];
            row_uses[i] = row_uses[i-1];
          end
          row_key[pos] = c.key;
          row_handler[pos] = c.handler;
          row_uses[pos] = '0;
          rows_held++;
        end
      end
      skt_pkg::OP_REMOVE: begin
        if (!hit) begin
          r.status = skt_pkg::ST_MISSING;
        end else begin
          for (i = pos; i + 1 < rows_held; i++) begin
            row_key[i] = row_key[i+1];
            row_handler[i] = row_handler[i+1];
            row_uses[i] = row_uses[i+1];
          end
          rows_held--;
        end
      end
      skt_pkg::OP_CALL: begin
        if (!hit) begin
          r.status = skt_pkg::ST_MISSING;
        end else begin
          row_uses[pos] = row_uses[pos] + 64'd1;
          r.handler_out = row_handler[pos];
          r.use_count = row_uses[pos];
        end
      end
      default: begin
        if (!hit) r.status = skt_pkg::ST_MISSING;
      end
    endcase
    r.entry_count = 7'(rows_held);
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    skt_pkg::out_t want;
    if (rst) begin
      rows_held = 0;
      expected_rsp_q.delete();
    end else begin
      if (done) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: unexpected response, expected none, actual %0h", $time, rsp);
          mismatches++;
        end else begin
          want = expected_rsp_q.pop_front();
          check_field("status", 64'(want.status), 64'(rsp.status));
          check_field("found", 64'(want.found), 64'(rsp.found));
          check_field("handler_out", 64'(want.handler_out), 64'(rsp.handler_out));
          check_field("use_count", want.use_count, rsp.use_count);
          check_field("entry_count", 64'(want.entry_count), 64'(rsp.entry_count));
        end
      end
      if (start && !busy) expected_rsp_q.push_back(table_outcome(cmd));
    end
    fail_count <= mismatches;
    pending_results <= expected_rsp_q.size();
  end

endmodule

FILE: tb/tb_sorted_key_table_with_hit_counts_core.sv
module tb_sorted_key_table_with_hit_counts_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic          clk;
  logic          rst;
  logic          start;
  logic          busy;
  logic          done;
  skt_pkg::in_t  cmd;
  skt_pkg::out_t rsp;
  int            fail_count;
  int            pending_results;

  // When clear, the command side never inserts idle cycles between transactions.
  bit          idle_enable;
  // Keys sent with insert commands; lookups draw from here so that most of them
  // land on keys that are, or recently were, in the table.
  logic [31:0] key_pool[$];

  sorted_key_table_with_hit_counts_core #(.TABLE_DEPTH(64)) u_dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .cmd  (cmd),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  // The checker sees the same command and response channels as the block and
  // owns all prediction; this module only produces traffic and the verdict.
  skt_result_checker #(.TABLE_DEPTH(64)) u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .cmd            (cmd),
    .done           (done),
    .rsp            (rsp),
    .fail_count     (fail_count),
    .pending_results(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // A correct run takes well under a fifth of this, even with every command
  // paying for a full-table shift.
  initial begin
    #10ms;
    $display("status: fail");
    $finish;
  end

  // Issues one command transaction. In each cycle the command side either idles
  // at random, with start low and junk on the command bus that the block must
  // ignore, or offers the new command with start high. The task returns at the
  // edge where the block takes the command with busy low. Start is left high on
  // return, so the next call can replace the command without a dead cycle.
  task automatic issue(input skt_pkg::func_t op, input logic [31:0] key,
                       input logic [31:0] handler);
    skt_pkg::in_t fresh_cmd;
    skt_pkg::in_t junk;
    bit           idle_now;
    fresh_cmd.func = op;
    fresh_cmd.key = key;
    fresh_cmd.handler = handler;
    forever begin
      idle_now = idle_enable && ($urandom_range(0, 99) < 24);
      if (idle_now) begin
        junk.func = skt_pkg::func_t'($urandom_range(0, 3));
        junk.key = $urandom;
        junk.handler = $urandom;
        start <= 1'b0;
        cmd <= junk;
      end else begin
        start <= 1'b1;
        cmd <= fresh_cmd;
      end
      @(posedge clk);
      if (!idle_now && busy === 1'b0) break;
    end
    if (op == skt_pkg::OP_INSERT) begin
      key_pool.push_back(key);
      if (key_pool.size() > 256) void'(key_pool.pop_front());
    end
  endtask

  // Stops issuing and waits until every outstanding response has come back.
  // The extra edge up front lets the checker count the last transaction.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  // Picks a key: with the given percent chance a previously inserted key,
  // otherwise a fresh one. Fresh keys are mostly full-width random so that every
  // key bit toggles, with some small values to force neighbors and some values
  // at the ends and the middle of the key range.
  function automatic logic [31:0] pick_key(int pool_pct);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < pool_pct && key_pool.size() > 0) begin
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    end
    sel = $urandom_range(0, 9);
    if (sel < 3) return $urandom_range(0, 127);
    if (sel == 3) begin
      case ($urandom_range(0, 3))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  initial begin
    int phase;
    int roll;
    int ins_lim;
    int rem_lim;
    int call_lim;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    idle_enable = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Lookups on an empty table must all miss.
    issue(skt_pkg::OP_EXISTS, 32'h0000_0000, 32'h0000_0000);
    issue(skt_pkg::OP_REMOVE, 32'h0000_0005, $urandom);
    issue(skt_pkg::OP_CALL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Build a three-row table from the middle outward so that one insert lands
    // in front of everything and one behind everything.
    issue(skt_pkg::OP_INSERT, 32'h8000_0000, 32'hA5A5_A5A5);
    issue(skt_pkg::OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    issue(skt_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
    // A second insert of a present key is rejected and leaves its handler alone.
    issue(skt_pkg::OP_INSERT, 32'h0000_0000, 32'h1234_5678);
    // Repeated calls count up from zero; exists queries never count.
    issue(skt_pkg::OP_CALL, 32'h0000_0000, $urandom);
    issue(skt_pkg::OP_CALL, 32'h0000_0000, $urandom);
    issue(skt_pkg::OP_EXISTS, 32'h0000_0000, $urandom);
    issue(skt_pkg::OP_CALL, 32'h0000_0000, $urandom);
    issue(skt_pkg::OP_CALL, 32'hFFFF_FFFF, $urandom);
    issue(skt_pkg::OP_EXISTS, 32'h8000_0000, $urandom);
    issue(skt_pkg::OP_EXISTS, 32'h7FFF_FFFF, $urandom);
    // Remove from the middle, the front and the back until the table is empty.
    issue(skt_pkg::OP_REMOVE, 32'h8000_0000, $urandom);
    issue(skt_pkg::OP_REMOVE, 32'h0000_0000, $urandom);
    issue(skt_pkg::OP_CALL, 32'h0000_0000, $urandom);
    issue(skt_pkg::OP_REMOVE, 32'hFFFF_FFFF, $urandom);
    issue(skt_pkg::OP_EXISTS, 32'hFFFF_FFFF, $urandom);
    // A re-inserted key starts counting from zero again.
    issue(skt_pkg::OP_INSERT, 32'h0000_0000, 32'h5A5A_5A5A);
    issue(skt_pkg::OP_CALL, 32'h0000_0000, $urandom);
    drain_results();

    // Random part, in phases of a hundred transactions that rotate through
    // insert-heavy (fills the table and runs into the full case), balanced,
    // remove-heavy (empties it again) and call-heavy mixes. Every phase starts
    // from an idle block, and one stretch runs with no idle cycles at all.
    for (int n = 0; n < 850; n++) begin
      if (n % 100 == 0) drain_results();
      idle_enable = !(n >= 400 && n < 550);
      phase = (n / 100) % 4;
      case (phase)
        0: begin ins_lim = 75; rem_lim = 80; call_lim = 95; end
        1: begin ins_lim = 35; rem_lim = 55; call_lim = 85; end
        2: begin ins_lim = 15; rem_lim = 65; call_lim = 85; end
        default: begin ins_lim = 25; rem_lim = 35; call_lim = 85; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < ins_lim) issue(skt_pkg::OP_INSERT, pick_key(15), $urandom);
      else if (roll < rem_lim) issue(skt_pkg::OP_REMOVE, pick_key(80), $urandom);
      else if (roll < call_lim) issue(skt_pkg::OP_CALL, pick_key(85), $urandom);
      else issue(skt_pkg::OP_EXISTS, pick_key(60), $urandom);
    end

    drain_results();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/skt_pkg.sv
hdl/skt_ram.sv
hdl/sorted_key_table_with_hit_counts_core.sv
tb/skt_result_checker.sv
tb/tb_sorted_key_table_with_hit_counts_core.sv
